// ===== design/csp_pkg.sv =====
// ----------------------------------------------------------------------------
// Call stack time profiler package
// Operation and status codes, and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package csp_pkg;

  localparam logic [1:0] OP_ENTER = 2'd0;
  localparam logic [1:0] OP_EXIT  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_STACK_FULL  = 3'd1;
  localparam logic [2:0] ST_STACK_EMPTY = 3'd2;
  localparam logic [2:0] ST_TABLE_FULL  = 3'd3;
  localparam logic [2:0] ST_DISABLED    = 3'd4;

  typedef struct packed {
    logic       latch;
    logic       stk_rd;
    logic       ent_upd;
    logic       push;
    logic       ex_calc;
    logic       scan_start;
    logic       scan_rd;
    logic       scan_cmp;
    logic       tbl_upd;
    logic       pop;
    logic       tbl_rd;
    logic       rd_res;
    logic       clr;
    logic       st_set;
    logic [2:0] st_code;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       en;
    logic       full;
    logic       empty;
    logic       idx_ok;
    logic       hit;
    logic       scan_last;
    logic       out_free;
  } sts_t;

endpackage

// ===== design/csp_ctrl.sv =====
// ----------------------------------------------------------------------------
// Call stack time profiler controller
// Sequences each request through the datapath, one request at a time.
// ----------------------------------------------------------------------------
module csp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  csp_pkg::sts_t sts_i,
  output csp_pkg::cmd_t cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_DECODE   = 11'b00000000010,
    S_ENT_RD   = 11'b00000000100,
    S_ENT_PUSH = 11'b00000001000,
    S_EX_RD    = 11'b00000010000,
    S_SCAN_RD  = 11'b00000100000,
    S_SCAN_CMP = 11'b00001000000,
    S_TUPD     = 11'b00010000000,
    S_POP      = 11'b00100000000,
    S_RD_WAIT  = 11'b01000000000,
    S_DONE     = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts_i.op)
          csp_pkg::OP_ENTER: begin
            if (!sts_i.en) begin
              cmd_o.st_set  = 1'b1;
              cmd_o.st_code = csp_pkg::ST_DISABLED;
              state_d       = S_DONE;
            end else if (sts_i.full) begin
              cmd_o.st_set  = 1'b1;
              cmd_o.st_code = csp_pkg::ST_STACK_FULL;
              state_d       = S_DONE;
            end else if (sts_i.empty) begin
              cmd_o.push = 1'b1;
              state_d    = S_DONE;
            end else begin
              cmd_o.stk_rd = 1'b1;
              state_d      = S_ENT_RD;
            end
          end
          csp_pkg::OP_EXIT: begin
            if (!sts_i.en) begin
              cmd_o.st_set  = 1'b1;
              cmd_o.st_code = csp_pkg::ST_DISABLED;
              state_d       = S_DONE;
            end else if (sts_i.empty) begin
              cmd_o.st_set  = 1'b1;
              cmd_o.st_code = csp_pkg::ST_STACK_EMPTY;
              state_d       = S_DONE;
            end else begin
              cmd_o.stk_rd = 1'b1;
              state_d      = S_EX_RD;
            end
          end
          csp_pkg::OP_READ: begin
            if (sts_i.idx_ok) begin
              cmd_o.tbl_rd = 1'b1;
              state_d      = S_RD_WAIT;
            end else begin
              state_d = S_DONE;
            end
          end
          default: begin
            cmd_o.clr = 1'b1;
            state_d   = S_DONE;
          end
        endcase
      end
      S_ENT_RD: begin
        cmd_o.ent_upd = 1'b1;
        state_d       = S_ENT_PUSH;
      end
      S_ENT_PUSH: begin
        cmd_o.push = 1'b1;
        state_d    = S_DONE;
      end
      S_EX_RD: begin
        cmd_o.ex_calc    = 1'b1;
        cmd_o.scan_start = 1'b1;
        state_d          = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        cmd_o.scan_rd = 1'b1;
        state_d       = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        cmd_o.scan_cmp = 1'b1;
        if (sts_i.hit || sts_i.scan_last) begin
          state_d = S_TUPD;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_TUPD: begin
        cmd_o.tbl_upd = 1'b1;
        state_d       = S_POP;
      end
      S_POP: begin
        cmd_o.pop = 1'b1;
        state_d   = S_DONE;
      end
      S_RD_WAIT: begin
        cmd_o.rd_res = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/csp_dp.sv =====
// ----------------------------------------------------------------------------
// Call stack time profiler datapath
// Holds the shadow stack, the statistics table, the request and result
// registers, and carries out the commands of the controller.
// ----------------------------------------------------------------------------
module csp_dp #(
  parameter int STACK_DEPTH   = 64,
  parameter int TABLE_ENTRIES = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  input  logic          cfg_collect_enable_i,
  input  logic [1:0]    op_i,
  input  logic [31:0]   func_addr_i,
  input  logic [63:0]   time_now_i,
  input  logic [7:0]    entry_index_i,
  input  logic          out_stall_i,
  output logic          out_valid_o,
  output logic [2:0]    status_o,
  output logic          entry_valid_o,
  output logic [31:0]   entry_addr_o,
  output logic [31:0]   entry_calls_o,
  output logic [63:0]   entry_inclusive_o,
  output logic [63:0]   entry_exclusive_o,
  input  csp_pkg::cmd_t cmd_i,
  output csp_pkg::sts_t sts_o
);

  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int SW = $clog2(STACK_DEPTH);
  localparam int TW = $clog2(TABLE_ENTRIES);

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] calls;
    logic [63:0] incl;
    logic [63:0] excl;
  } slot_t;

  // Stack and table stores.
  logic [31:0] func_mem [STACK_DEPTH];
  logic [63:0] ent_mem  [STACK_DEPTH];
  logic [63:0] res_mem  [STACK_DEPTH];
  logic [63:0] own_mem  [STACK_DEPTH];
  slot_t       tbl_mem  [TABLE_ENTRIES];

  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [DW-1:0]            depth_q;
  logic                     en_q;

  // Request registers.
  logic [1:0]  op_q;
  logic [31:0] addr_q;
  logic [63:0] now_q;
  logic [7:0]  idx_q;

  // Read data and working registers.
  logic [31:0] rd_func_q;
  logic [63:0] rd_ent_q, rd_res_q, rd_own_q;
  slot_t       tbl_rd_q;
  logic [63:0] incl_q, excl_q;
  logic [TW-1:0] scan_q, slot_q, free_q;
  logic        have_q, have_free_q;

  // Result and output registers.
  logic [2:0]  res_status_q;
  logic        res_valid_q;
  slot_t       res_slot_q;
  logic        out_valid_q;

  logic [SW-1:0] top_idx, push_idx, below_idx;
  logic [TW-1:0] rd_idx, tbl_raddr;
  logic          hit;

  assign top_idx   = SW'(depth_q - DW'(1));
  assign push_idx  = SW'(depth_q);
  assign below_idx = SW'(depth_q - DW'(2));
  assign rd_idx    = TW'(idx_q);
  assign tbl_raddr = cmd_i.tbl_rd ? rd_idx : scan_q;
  assign hit       = valid_q[scan_q] && (tbl_rd_q.addr == addr_q);

  assign sts_o.op        = op_q;
  assign sts_o.en        = en_q;
  assign sts_o.full      = (depth_q == DW'(STACK_DEPTH));
  assign sts_o.empty     = (depth_q == '0);
  assign sts_o.idx_ok    = (int'(idx_q) < TABLE_ENTRIES);
  assign sts_o.hit       = hit;
  assign sts_o.scan_last = (scan_q == TW'(TABLE_ENTRIES - 1));
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  // Stack stores.
  always_ff @(posedge clk_i) begin
    if (cmd_i.stk_rd) begin
      rd_func_q <= func_mem[top_idx];
      rd_ent_q  <= ent_mem[top_idx];
      rd_res_q  <= res_mem[top_idx];
      rd_own_q  <= own_mem[top_idx];
    end
    if (cmd_i.push) begin
      func_mem[push_idx] <= addr_q;
      ent_mem[push_idx]  <= now_q;
    end
    if (cmd_i.push) begin
      res_mem[push_idx] <= now_q;
    end else if (cmd_i.pop && (depth_q > DW'(1))) begin
      res_mem[below_idx] <= now_q;
    end
    if (cmd_i.push) begin
      own_mem[push_idx] <= '0;
    end else if (cmd_i.ent_upd) begin
      own_mem[top_idx] <= rd_own_q + (now_q - rd_res_q);
    end
  end

  // Statistics table store.
  always_ff @(posedge clk_i) begin
    if (cmd_i.tbl_rd || cmd_i.scan_rd) begin
      tbl_rd_q <= tbl_mem[tbl_raddr];
    end
    if (cmd_i.tbl_upd) begin
      if (have_q) begin
        tbl_mem[slot_q] <= '{addr:  tbl_rd_q.addr,
                             calls: tbl_rd_q.calls + 32'd1,
                             incl:  tbl_rd_q.incl + incl_q,
                             excl:  tbl_rd_q.excl + excl_q};
      end else if (have_free_q) begin
        tbl_mem[free_q] <= '{addr: rd_func_q, calls: 32'd1, incl: incl_q, excl: excl_q};
      end
    end
  end

  // Payload registers without reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q   <= op_i;
      addr_q <= func_addr_i;
      now_q  <= time_now_i;
      idx_q  <= entry_index_i;
    end
    if (cmd_i.ex_calc) begin
      incl_q <= now_q - rd_ent_q;
      excl_q <= rd_own_q + (now_q - rd_res_q);
      addr_q <= rd_func_q;
    end
    if (cmd_i.scan_start) begin
      scan_q <= '0;
    end else if (cmd_i.scan_cmp) begin
      scan_q <= scan_q + TW'(1);
    end
    if (cmd_i.scan_cmp) begin
      if (hit) begin
        slot_q <= scan_q;
      end else if (!valid_q[scan_q] && !have_free_q) begin
        free_q <= scan_q;
      end
    end
    if (cmd_i.latch) begin
      res_slot_q <= '0;
    end else if (cmd_i.rd_res && valid_q[rd_idx]) begin
      res_slot_q <= tbl_rd_q;
    end
    if (cmd_i.out_load) begin
      status_o          <= res_status_q;
      entry_valid_o     <= res_valid_q;
      entry_addr_o      <= res_slot_q.addr;
      entry_calls_o     <= res_slot_q.calls;
      entry_inclusive_o <= res_slot_q.incl;
      entry_exclusive_o <= res_slot_q.excl;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q         <= 1'b1;
      depth_q      <= '0;
      valid_q      <= '0;
      have_q       <= 1'b0;
      have_free_q  <= 1'b0;
      res_status_q <= csp_pkg::ST_OK;
      res_valid_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        en_q <= cfg_collect_enable_i;
      end
      if (cmd_i.push) begin
        depth_q <= depth_q + DW'(1);
      end else if (cmd_i.pop) begin
        depth_q <= depth_q - DW'(1);
      end
      if (cmd_i.clr) begin
        valid_q <= '0;
      end else if (cmd_i.tbl_upd && !have_q && have_free_q) begin
        valid_q[free_q] <= 1'b1;
      end
      if (cmd_i.scan_start) begin
        have_q      <= 1'b0;
        have_free_q <= 1'b0;
      end else if (cmd_i.scan_cmp) begin
        if (hit) begin
          have_q <= 1'b1;
        end else if (!valid_q[scan_q]) begin
          have_free_q <= 1'b1;
        end
      end
      if (cmd_i.latch) begin
        res_status_q <= csp_pkg::ST_OK;
        res_valid_q  <= 1'b0;
      end else if (cmd_i.st_set) begin
        res_status_q <= cmd_i.st_code;
      end else if (cmd_i.tbl_upd && !have_q && !have_free_q) begin
        res_status_q <= csp_pkg::ST_TABLE_FULL;
      end else if (cmd_i.rd_res) begin
        res_valid_q <= valid_q[rd_idx];
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DW'(STACK_DEPTH))
    else $error("stack depth beyond its bound");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> (depth_q != DW'(STACK_DEPTH)))
    else $error("push on a full stack");
  a_pop_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> (depth_q != '0))
    else $error("pop on an empty stack");
  a_hit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.tbl_upd && have_q) |-> valid_q[slot_q])
    else $error("update of a free slot");

endmodule

// ===== design/call_stack_time_profiler.sv =====
// ----------------------------------------------------------------------------
// Call stack time profiler
// Shadow stack of open calls with a per-function table of call counts,
// inclusive and exclusive time.
// ----------------------------------------------------------------------------
// Usage: a request enters on the input channel (in_valid_i, in_stall_o) with
// an operation, a function address, a timestamp and a table index. Every
// request yields exactly one result on the output channel (out_valid_o,
// out_stall_i): a status and, for a read, the contents of one table slot.
// One request is handled at a time, and the result becomes valid in the cycle
// in which the next request can first be accepted. Disabled, stack full,
// stack empty and clear requests, an enter onto an empty stack and a read
// beyond the table are handled in the decode step; a read first reads its
// table slot; an enter with an open caller first reads the caller's frame
// and updates the caller's own time, then pushes. An exit reads the top frame,
// then walks the table slot by slot, reading and comparing each, up to the hit
// slot or the last slot, then updates the table and pops; one read port.
// The result sits in an output register; if the receiver stalls, the next
// request holds in its final step until the register frees.
// The collect_enable register is written on the configuration channel,
// which is always ready. Reset empties the stack and the table and sets
// collect_enable; there is no clearing pass.
// ----------------------------------------------------------------------------
module call_stack_time_profiler #(
  parameter int STACK_DEPTH   = 64,
  parameter int TABLE_ENTRIES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_collect_enable_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [31:0] func_addr_i,
  input  logic [63:0] time_now_i,
  input  logic [7:0]  entry_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic        entry_valid_o,
  output logic [31:0] entry_addr_o,
  output logic [31:0] entry_calls_o,
  output logic [63:0] entry_inclusive_o,
  output logic [63:0] entry_exclusive_o
);

  csp_pkg::cmd_t cmd;
  csp_pkg::sts_t sts;

  // The enable register can be written in any cycle.
  assign cfg_ready_o = 1'b1;

  csp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  csp_dp #(
    .STACK_DEPTH   (STACK_DEPTH),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_collect_enable_i (cfg_collect_enable_i),
    .op_i                 (op_i),
    .func_addr_i          (func_addr_i),
    .time_now_i           (time_now_i),
    .entry_index_i        (entry_index_i),
    .out_stall_i          (out_stall_i),
    .out_valid_o          (out_valid_o),
    .status_o             (status_o),
    .entry_valid_o        (entry_valid_o),
    .entry_addr_o         (entry_addr_o),
    .entry_calls_o        (entry_calls_o),
    .entry_inclusive_o    (entry_inclusive_o),
    .entry_exclusive_o    (entry_exclusive_o),
    .cmd_i                (cmd),
    .sts_o                (sts)
  );

endmodule
